/* rtl/core/cas_pkg.sv */
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants of the argument splitter
// Byte codes, counter limits, the result record and the queue geometry.
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_TAB       = 8'h09;

    // saturation limits of the backslash run and the argument counter
    localparam logic [7:0]  RUN_MAX      = 8'd255;
    localparam logic [15:0] ARG_MAX      = 16'hFFFF;

    // result queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_BACKSLASH,
        CLS_QUOTE,
        CLS_BLANK,
        CLS_OTHER
    } t_byte_class;

    typedef struct packed {
        logic [7:0]  backslash_run;
        logic        has_char;
        logic [7:0]  char_out;
        logic        ends_argument;
        logic [15:0] argument_number;
        logic        command_done;
    } t_result;

    // one result request moving between stages
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_req;

    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        if (b == CH_BACKSLASH) begin
            c = CLS_BACKSLASH;
        end else if (b == CH_QUOTE) begin
            c = CLS_QUOTE;
        end else if (b == CH_SPACE || b == CH_TAB) begin
            c = CLS_BLANK;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

/* rtl/core/cas_front.sv */
// ----------------------------------------------------------------------------
// cas_front: byte classifier and tokenizer state
// Holds the quoting/backslash state and turns each accepted byte into
// zero or one result request.
// ----------------------------------------------------------------------------
module cas_front import cas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output t_res_req   o_req
);

    logic        r_in_arg, n_in_arg;
    logic        r_in_quotes, n_in_quotes;
    logic [7:0]  r_pend, n_pend;
    logic        r_watch, n_watch;
    logic [15:0] r_argc, n_argc;

    t_byte_class cls;
    logic        emit;
    logic        close_arg;
    t_result     res;

    assign cls = classify(i_in_byte);

    always_comb begin
        n_in_arg    = r_in_arg;
        n_in_quotes = r_in_quotes;
        n_pend      = r_pend;
        n_watch     = 1'b0;
        emit        = 1'b0;
        close_arg   = 1'b0;
        res.backslash_run   = 8'd0;
        res.has_char        = 1'b0;
        res.char_out        = 8'd0;
        res.ends_argument   = 1'b0;
        res.argument_number = r_argc;
        res.command_done    = i_is_final;

        if (r_watch && cls == CLS_QUOTE) begin
            // second quote of a doubled pair inside quotes
            emit         = 1'b1;
            res.has_char = 1'b1;
            res.char_out = CH_QUOTE;
        end else begin
            case (cls)
                CLS_BACKSLASH: begin
                    n_in_arg = 1'b1;
                    if (r_pend < RUN_MAX) begin
                        n_pend = r_pend + 8'd1;
                    end
                end
                CLS_QUOTE: begin
                    n_in_arg          = 1'b1;
                    n_watch           = r_in_quotes;
                    res.backslash_run = {1'b0, r_pend[7:1]};
                    if (r_pend[0]) begin
                        res.has_char = 1'b1;
                        res.char_out = CH_QUOTE;
                    end else begin
                        n_in_quotes = ~r_in_quotes;
                    end
                    emit   = (r_pend[7:1] != 7'd0) || r_pend[0];
                    n_pend = 8'd0;
                end
                CLS_BLANK: begin
                    if (r_in_arg) begin
                        res.backslash_run = r_pend;
                        n_pend            = 8'd0;
                        emit              = 1'b1;
                        if (r_in_quotes) begin
                            res.has_char = 1'b1;
                            res.char_out = i_in_byte;
                        end else begin
                            res.ends_argument = 1'b1;
                            n_in_arg          = 1'b0;
                            close_arg         = 1'b1;
                        end
                    end
                end
                default: begin
                    n_in_arg          = 1'b1;
                    res.backslash_run = r_pend;
                    n_pend            = 8'd0;
                    emit              = 1'b1;
                    res.has_char      = 1'b1;
                    res.char_out      = i_in_byte;
                end
            endcase
        end

        // counter advance; a final byte resets everything below anyway
        n_argc = r_argc;
        if (close_arg && r_argc < ARG_MAX) begin
            n_argc = r_argc + 16'd1;
        end

        if (i_is_final) begin
            emit = 1'b1;
            if (n_in_arg) begin
                // run and pending are never both nonzero here
                res.backslash_run = res.backslash_run + n_pend;
                res.ends_argument = 1'b1;
            end
            n_in_arg    = 1'b1;
            n_in_quotes = 1'b0;
            n_pend      = 8'd0;
            n_watch     = 1'b0;
            n_argc      = 16'd0;
        end
    end

    assign o_req.valid = i_accept && emit;
    assign o_req.data  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_arg    <= 1'b1;
            r_in_quotes <= 1'b0;
            r_pend      <= 8'd0;
            r_watch     <= 1'b0;
            r_argc      <= 16'd0;
        end else if (i_accept) begin
            r_in_arg    <= n_in_arg;
            r_in_quotes <= n_in_quotes;
            r_pend      <= n_pend;
            r_watch     <= n_watch;
            r_argc      <= n_argc;
        end
    end

endmodule

/* rtl/core/cas_fifo.sv */
// ----------------------------------------------------------------------------
// cas_fifo: short result queue between front and back
// Decouples the tokenizer from the output stage; full stops byte intake.
// ----------------------------------------------------------------------------
module cas_fifo import cas_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_res_req i_req,
    input  logic     i_pop,
    output t_res_req o_head,
    output logic     o_full
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, n_wptr;
    logic [FIFO_AW-1:0]   r_rptr, n_rptr;
    logic [FIFO_CW-1:0]   r_cnt, n_cnt;
    logic                 do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
        logic [FIFO_AW-1:0] q;
        if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + FIFO_AW'(1);
        end
        return q;
    endfunction

    always_comb begin
        n_wptr = i_req.valid ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = do_pop ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (i_req.valid && !do_pop) begin
            n_cnt = r_cnt + FIFO_CW'(1);
        end else if (!i_req.valid && do_pop) begin
            n_cnt = r_cnt - FIFO_CW'(1);
        end
    end

    assign o_full       = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_mem[r_wptr] <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* rtl/core/cas_back.sv */
// ----------------------------------------------------------------------------
// cas_back: result output register
// Presents the oldest result and refills from the queue as it is popped.
// ----------------------------------------------------------------------------
module cas_back import cas_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_res_req i_head,
    output logic     o_take,
    input  logic     i_pop,
    output logic     o_empty,
    output t_result  o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_take = i_head.valid && (!r_valid || i_pop);

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    assign o_empty = ~r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

/* rtl/core/command_line_argument_splitter.sv */
// ----------------------------------------------------------------------------
// command_line_argument_splitter: command-line argument tokenizer
// Splits a byte stream into arguments under backslash and quote rules.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake             payload
// -------   ---  --------------------  ------------------------------------
// input     in   push / full           in_byte, is_final
// result    out  empty / pop           backslash_run, has_char, char_out,
//                                      ends_argument, argument_number,
//                                      command_done
//
// One byte is taken per clock while full is low. A byte that makes a result
// is written into the result queue, then taken into the output register,
// which drives the result ports. Bytes that make no result (a backslash, a
// bare quote toggle, blanks between arguments) leave nothing behind.
// full rises only when the four-entry result queue is full, i.e. when the
// consumer has stalled; the output register keeps one more result.
// Synchronous active-low reset clears tokenizer state, queue and output.
//
module command_line_argument_splitter import cas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_final,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_backslash_run,
    output logic        o_has_char,
    output logic [7:0]  o_char_out,
    output logic        o_ends_argument,
    output logic [15:0] o_argument_number,
    output logic        o_command_done
);

    t_res_req front_req;    // result request from the tokenizer
    t_res_req fifo_head;    // oldest queued result
    logic     back_take;    // output register pulls the queue head
    logic     in_accept;
    t_result  res;

    // a pushed byte is taken whenever the queue has room
    assign in_accept = push && !full;

    // front: classification and quote/backslash state
    cas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_in_byte  (i_in_byte),
        .i_is_final (i_is_final),
        .o_req      (front_req)
    );

    // queue between front and back; each side stalls on its own
    cas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (front_req),
        .i_pop   (back_take),
        .o_head  (fifo_head),
        .o_full  (full)
    );

    // back: output register facing the consumer
    cas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (fifo_head),
        .o_take  (back_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_backslash_run   = res.backslash_run;
    assign o_has_char        = res.has_char;
    assign o_char_out        = res.char_out;
    assign o_ends_argument   = res.ends_argument;
    assign o_argument_number = res.argument_number;
    assign o_command_done    = res.command_done;

endmodule

/* tb/cas_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_result_checker: scoreboard for the argument splitter
// Watches both queue ports, tracks the tokenizer state on every accepted
// byte, queues the piece each byte should produce and compares it field by
// field with the result that is popped.
// ----------------------------------------------------------------------------
module cas_result_checker import cas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_final,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_backslash_run,
    input  logic        i_has_char,
    input  logic [7:0]  i_char_out,
    input  logic        i_ends_argument,
    input  logic [15:0] i_argument_number,
    input  logic        i_command_done,
    output int          o_fail_count,
    output int          o_outstanding
);

    // tokenizer state as the block should hold it
    logic        in_arg;
    logic        quoted;
    logic [7:0]  bs_run;
    logic        quote_watch;
    logic [15:0] arg_index;

    t_result expected_pieces[$];
    int      fails;

    initial begin
        fails         = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    task automatic clear_state();
        in_arg      = 1'b1;
        quoted      = 1'b0;
        bs_run      = '0;
        quote_watch = 1'b0;
        arg_index   = '0;
    endtask

    task automatic close_arg();
        if (arg_index != ARG_MAX) begin
            arg_index = arg_index + 16'd1;
        end
    endtask

    // advance the tokenizer by one byte; emit says whether a piece comes out
    task automatic split_byte(input logic [7:0] b, input logic fin,
                              output logic emit, output t_result piece);
        logic [7:0]  run;
        logic        has;
        logic [7:0]  ch;
        logic        ends;
        logic [15:0] argno;
        logic [7:0]  n;
        emit  = 1'b0;
        run   = '0;
        has   = 1'b0;
        ch    = '0;
        ends  = 1'b0;
        argno = arg_index;
        if (quote_watch && b == CH_QUOTE) begin
            quote_watch = 1'b0;
            emit        = 1'b1;
            has         = 1'b1;
            ch          = CH_QUOTE;
        end else begin
            quote_watch = 1'b0;
            if (b == CH_BACKSLASH) begin
                in_arg = 1'b1;
                if (bs_run != RUN_MAX) begin
                    bs_run = bs_run + 8'd1;
                end
            end else if (b == CH_QUOTE) begin
                n           = bs_run;
                in_arg      = 1'b1;
                quote_watch = quoted;
                run         = n >> 1;
                if (n[0]) begin
                    has = 1'b1;
                    ch  = CH_QUOTE;
                end else begin
                    quoted = !quoted;
                end
                emit   = (run != 0) || has;
                bs_run = '0;
            end else if (b == CH_SPACE || b == CH_TAB) begin
                if (in_arg) begin
                    run    = bs_run;
                    bs_run = '0;
                    emit   = 1'b1;
                    if (quoted) begin
                        has = 1'b1;
                        ch  = b;
                    end else begin
                        ends   = 1'b1;
                        in_arg = 1'b0;
                        close_arg();
                    end
                end
            end else begin
                in_arg = 1'b1;
                run    = bs_run;
                bs_run = '0;
                emit   = 1'b1;
                has    = 1'b1;
                ch     = b;
            end
        end
        if (fin) begin
            emit = 1'b1;
            if (in_arg) begin
                run    = run + bs_run;
                bs_run = '0;
                ends   = 1'b1;
                close_arg();
            end
        end
        piece.backslash_run   = run;
        piece.has_char        = has;
        piece.char_out        = has ? ch : 8'h00;
        piece.ends_argument   = ends;
        piece.argument_number = argno;
        piece.command_done    = fin;
        if (fin) begin
            clear_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        logic    emit;
        t_result piece;
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            expected_pieces.delete();
        end else begin
            if (i_push && !i_full) begin
                split_byte(i_in_byte, i_is_final, emit, piece);
                if (emit) begin
                    expected_pieces.push_back(piece);
                end
            end
            if (i_pop && !i_empty) begin
                if (expected_pieces.size() == 0) begin
                    report_mismatch("unexpected result, argument_number",
                                    i_argument_number, 16'h0);
                end else begin
                    want = expected_pieces.pop_front();
                    check_field("backslash_run", 16'(i_backslash_run),
                                16'(want.backslash_run));
                    check_field("has_char", 16'(i_has_char), 16'(want.has_char));
                    check_field("char_out", 16'(i_char_out), 16'(want.char_out));
                    check_field("ends_argument", 16'(i_ends_argument),
                                16'(want.ends_argument));
                    check_field("argument_number", i_argument_number,
                                want.argument_number);
                    check_field("command_done", 16'(i_command_done),
                                16'(want.command_done));
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_pieces.size();
    end

endmodule

/* tb/tb_command_line_argument_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_line_argument_splitter: top of the argument splitter bench
// Feeds directed command lines, long backslash runs that saturate the
// pending count, and random command lines through the byte queue, with
// random idle cycles on both ports. The checker beside the block predicts
// every piece; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_command_line_argument_splitter;
    import cas_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 900;
    localparam int DRAIN_CYCLES  = 16;
    localparam int OPENING_LEN   = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        is_final;
    logic        empty;
    logic        pop;
    logic [7:0]  backslash_run;
    logic        has_char;
    logic [7:0]  char_out;
    logic        ends_argument;
    logic [15:0] argument_number;
    logic        command_done;

    int fail_count;
    int outstanding;
    int cycles;

    bit tx_calm;
    bit rx_calm;
    int tx_count;
    int rx_count;

    command_line_argument_splitter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_in_byte         (in_byte),
        .i_is_final        (is_final),
        .empty             (empty),
        .pop               (pop),
        .o_backslash_run   (backslash_run),
        .o_has_char        (has_char),
        .o_char_out        (char_out),
        .o_ends_argument   (ends_argument),
        .o_argument_number (argument_number),
        .o_command_done    (command_done)
    );

    cas_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_in_byte         (in_byte),
        .i_is_final        (is_final),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_backslash_run   (backslash_run),
        .i_has_char        (has_char),
        .i_char_out        (char_out),
        .i_ends_argument   (ends_argument),
        .i_argument_number (argument_number),
        .i_command_done    (command_done),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends here
    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[command_line_argument_splitter] ERROR");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit calm);
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // one request on the byte queue: idle first, then hold push until taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (tx_count % 40 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_count++;
        gap = idle_cycles(tx_calm);
        for (int k = 0; k < gap; k++) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        in_byte  <= b;
        is_final <= fin;
        do @(posedge i_clk); while (full);
    endtask

    // byte mix for random command lines: heavy on backslashes and quotes so
    // the run and quote rules get exercised, the rest any byte at all
    function automatic logic [7:0] noise_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            return CH_BACKSLASH;
        end else if (pick < 40) begin
            return CH_QUOTE;
        end else if (pick < 50) begin
            return CH_SPACE;
        end else if (pick < 55) begin
            return CH_TAB;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // directed opening, {is_final, byte}:
    //  - leading blank closes an empty argument, zero byte and 0xFF as chars
    //  - blanks between arguments, even run before a quote opens quoting
    //  - blank inside quotes, closing quote followed by a doubled quote
    //  - odd run inside quotes, then a doubled quote after it
    //  - command ends with quotes still open
    //  - command ends on pending backslashes
    //  - command ends on blanks outside any argument
    logic [8:0] opening [0:OPENING_LEN-1] = '{
        {1'b0, CH_SPACE}, {1'b0, 8'h61}, {1'b0, 8'h00}, {1'b0, 8'hFF},
        {1'b0, CH_TAB}, {1'b0, CH_SPACE}, {1'b0, CH_BACKSLASH},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE}, {1'b0, 8'h78},
        {1'b0, CH_SPACE}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
        {1'b0, CH_QUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE},
        {1'b0, CH_QUOTE}, {1'b1, 8'h7A},
        {1'b0, CH_BACKSLASH}, {1'b0, CH_BACKSLASH}, {1'b1, CH_BACKSLASH},
        {1'b0, 8'h71}, {1'b0, CH_SPACE}, {1'b1, CH_SPACE}
    };

    // result side: random stall before each pop, sometimes none for a while
    initial begin
        int gap;
        pop      <= 1'b0;
        rx_count = 0;
        rx_calm  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_count % 40 == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            rx_count++;
            gap = idle_cycles(rx_calm);
            for (int k = 0; k < gap; k++) begin
                pop <= 1'b0;
                @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // byte side and verdict
    initial begin
        int random_sent;
        int len;
        i_rst_n  <= 1'b0;
        push     <= 1'b0;
        in_byte  <= '0;
        is_final <= 1'b0;
        tx_calm  = 1'b0;
        tx_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < OPENING_LEN; i++) begin
            send_byte(opening[i][7:0], opening[i][8]);
        end

        // long backslash run: the pending count stops at its ceiling
        repeat (300) send_byte(CH_BACKSLASH, 1'b0);
        send_byte(8'h61, 1'b0);
        repeat (257) send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b1);

        // random command lines, each closed by a final byte
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                send_byte(noise_byte(), i == len - 1);
            end
            random_sent += len;
        end
        push <= 1'b0;

        // let every expected piece come out, then watch for strays
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[command_line_argument_splitter] OK");
        end else begin
            $display("[command_line_argument_splitter] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/cas_pkg.sv
rtl/core/cas_front.sv
rtl/core/cas_fifo.sv
rtl/core/cas_back.sv
rtl/core/command_line_argument_splitter.sv
tb/cas_result_checker.sv
tb/tb_command_line_argument_splitter.sv
